@@ rtl/core/fddls_pkg.sv @@
package fddls_pkg;

   localparam logic [13:0] VALUE_MAX        = 14'd9999;
   localparam logic [7:0]  CMD_DATA_MODE    = 8'h44;
   localparam logic [7:0]  CMD_ADDRESS_BASE = 8'hC0;
   localparam logic [7:0]  CMD_DISPLAY_ON   = 8'h8A;
   localparam logic [7:0]  POINT_MASK_RESET = 8'h80;
   localparam logic [3:0]  SEG_ACK          = 4'd8;
   localparam logic [3:0]  SEG_STOP         = 4'd9;
   localparam logic [3:0]  SEG_START        = 4'd10;
   localparam logic [2:0]  LAST_FRAME       = 3'd5;

   typedef enum logic [1:0] {
      CSR_SEG_LOW    = 2'd0,
      CSR_SEG_HIGH   = 2'd1,
      CSR_POINT_MASK = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic        opcode;
      logic [13:0] shown_value;
   } req_payload_type;

   typedef struct packed {
      logic clock_pin;
      logic data_pin;
      logic sending;
      logic update_finished;
      logic load_accepted;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]  reg_index;
      logic [63:0] write_data;
   } csr_payload_type;

   typedef struct packed {
      logic        is_load;
      logic [13:0] value;
   } item_type;

   typedef struct packed {
      logic        start;
      logic [13:0] value;
   } bcd_req_type;

   typedef logic [3:0][3:0] digits_type;

endpackage

@@ rtl/core/fddls_chan_if.sv @@
interface fddls_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/fddls_front.sv @@
module fddls_front (
   fddls_chan_if.sink          req,
   output logic                push_valid,
   input  logic                push_ready,
   output fddls_pkg::item_type push_item
);
   import fddls_pkg::*;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   always_comb begin
      push_item.is_load = req.payload.opcode;
      if (req.payload.shown_value > VALUE_MAX) begin
         push_item.value = VALUE_MAX;
      end else begin
         push_item.value = req.payload.shown_value;
      end
   end

endmodule

@@ rtl/core/fddls_queue.sv @@
module fddls_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  fddls_pkg::item_type push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output fddls_pkg::item_type pop_item
);
   import fddls_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   item_type         store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/fddls_bcd.sv @@
module fddls_bcd (
   input  logic                   clock,
   input  fddls_pkg::bcd_req_type bcd_req,
   output fddls_pkg::digits_type  digits
);
   import fddls_pkg::*;

   logic [13:0] value_ff;
   logic [3:0]  thou_ff;
   logic [9:0]  rem1_ff;
   logic [3:0]  thou2_ff;
   logic [3:0]  hund_ff;
   logic [6:0]  rem2_ff;
   digits_type  digits_ff;
   logic [17:0] split1;
   logic [17:0] split2;
   logic [17:0] split3;

   // Returns the decimal digit in the top four bits and the remainder below.
   function automatic logic [17:0] digit_split(input logic [13:0] value,
                                               input logic [13:0] base);
      logic [3:0]  digit;
      logic [13:0] rest;
      logic [13:0] multiple;
      digit = 4'd0;
      rest  = value;
      for (int k = 1; k < 10; k++) begin
         multiple = 14'(k) * base;
         if (value >= multiple) begin
            digit = 4'(k);
            rest  = value - multiple;
         end
      end
      return {digit, rest};
   endfunction

   assign split1 = digit_split(value_ff, 14'd1000);
   assign split2 = digit_split({4'd0, rem1_ff}, 14'd100);
   assign split3 = digit_split({7'd0, rem2_ff}, 14'd10);

   always_ff @(posedge clock) begin
      if (bcd_req.start) begin
         value_ff <= bcd_req.value;
      end
      thou_ff      <= split1[17:14];
      rem1_ff      <= split1[9:0];
      thou2_ff     <= thou_ff;
      hund_ff      <= split2[17:14];
      rem2_ff      <= split2[6:0];
      digits_ff[0] <= thou2_ff;
      digits_ff[1] <= hund_ff;
      digits_ff[2] <= split3[17:14];
      digits_ff[3] <= split3[3:0];
   end

   assign digits = digits_ff;

endmodule

@@ rtl/core/fddls_back.sv @@
module fddls_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  fddls_pkg::item_type    pop_item,
   fddls_chan_if.sink             csr,
   output fddls_pkg::bcd_req_type bcd_req,
   input  fddls_pkg::digits_type  digits,
   fddls_chan_if.source           rsp
);
   import fddls_pkg::*;

   logic [63:0]     seg_low_ff;
   logic [15:0]     seg_high_ff;
   logic [7:0]      point_mask_ff;
   logic            clock_ff, clock_in;
   logic            data_ff, data_in;
   logic [2:0]      frame_ff, frame_in;
   logic            byte_ff, byte_in;
   logic [3:0]      bit_ff, bit_in;
   logic [1:0]      phase_ff, phase_in;
   logic            busy_ff, busy_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   logic            take;
   logic            finished;
   logic            accepted;
   logic            frame_has_data;
   logic [1:0]      digit_sel;
   logic [3:0]      digit;
   logic [7:0]      seg_byte;
   logic [7:0]      out_byte;

   assign csr.ready   = 1'b1;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_payload_ff;
   assign pop_ready   = !rsp_valid_ff || rsp.ready;
   assign take        = pop_valid && pop_ready;

   assign frame_has_data = (frame_ff >= 3'd1) && (frame_ff <= 3'd4);
   assign digit_sel      = frame_ff[1:0] - 2'd1;
   assign digit          = digits[digit_sel];

   always_comb begin
      if (digit < 4'd8) begin
         seg_byte = seg_low_ff[{digit[2:0], 3'b000} +: 8];
      end else if (digit < 4'd10) begin
         seg_byte = seg_high_ff[{digit[0], 3'b000} +: 8];
      end else begin
         seg_byte = 8'd0;
      end
      if (frame_ff == 3'd0) begin
         out_byte = CMD_DATA_MODE;
      end else if (frame_ff >= LAST_FRAME) begin
         out_byte = CMD_DISPLAY_ON;
      end else if (!byte_ff) begin
         out_byte = CMD_ADDRESS_BASE + {6'd0, digit_sel};
      end else if (digit_sel == 2'd1) begin
         out_byte = seg_byte | point_mask_ff;
      end else begin
         out_byte = seg_byte;
      end
   end

   always_comb begin
      clock_in      = clock_ff;
      data_in       = data_ff;
      frame_in      = frame_ff;
      byte_in       = byte_ff;
      bit_in        = bit_ff;
      phase_in      = phase_ff;
      busy_in       = busy_ff;
      finished      = 1'b0;
      accepted      = 1'b0;
      bcd_req.start = 1'b0;
      bcd_req.value = pop_item.value;
      if (take) begin
         if (pop_item.is_load) begin
            if (!busy_ff) begin
               bcd_req.start = 1'b1;
               frame_in      = 3'd0;
               byte_in       = 1'b0;
               bit_in        = SEG_START;
               phase_in      = 2'd0;
               busy_in       = 1'b1;
               accepted      = 1'b1;
            end
         end else if (busy_ff) begin
            if (bit_ff < SEG_ACK) begin
               if (phase_ff == 2'd0) begin
                  clock_in = 1'b0;
               end else if (phase_ff == 2'd1) begin
                  data_in = out_byte[bit_ff[2:0]];
               end else begin
                  clock_in = 1'b1;
               end
               if (phase_ff >= 2'd2) begin
                  phase_in = 2'd0;
                  bit_in   = bit_ff + 4'd1;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end else if (bit_ff == SEG_ACK) begin
               if (phase_ff == 2'd0) begin
                  clock_in = 1'b0;
               end else if (phase_ff == 2'd1) begin
                  data_in = 1'b1;
               end else begin
                  clock_in = 1'b1;
               end
               if (phase_ff >= 2'd2) begin
                  phase_in = 2'd0;
                  if (!byte_ff && frame_has_data) begin
                     byte_in = 1'b1;
                     bit_in  = 4'd0;
                  end else begin
                     bit_in = SEG_STOP;
                  end
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end else if (bit_ff == SEG_STOP) begin
               case (phase_ff)
                  2'd0:    clock_in = 1'b0;
                  2'd1:    data_in  = 1'b0;
                  2'd2:    clock_in = 1'b1;
                  default: data_in  = 1'b1;
               endcase
               if (phase_ff == 2'd3) begin
                  phase_in = 2'd0;
                  byte_in  = 1'b0;
                  if (frame_ff >= LAST_FRAME) begin
                     frame_in = 3'd0;
                     bit_in   = 4'd0;
                     busy_in  = 1'b0;
                     finished = 1'b1;
                  end else begin
                     frame_in = frame_ff + 3'd1;
                     bit_in   = SEG_START;
                  end
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end else begin
               if (phase_ff == 2'd0) begin
                  clock_in = 1'b1;
                  data_in  = 1'b1;
               end else if (phase_ff == 2'd1) begin
                  data_in = 1'b0;
               end else begin
                  clock_in = 1'b0;
               end
               if (phase_ff >= 2'd2) begin
                  phase_in = 2'd0;
                  bit_in   = 4'd0;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff     <= 1'b1;
         data_ff      <= 1'b1;
         frame_ff     <= 3'd0;
         byte_ff      <= 1'b0;
         bit_ff       <= 4'd0;
         phase_ff     <= 2'd0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clock_ff <= clock_in;
         data_ff  <= data_in;
         frame_ff <= frame_in;
         byte_ff  <= byte_in;
         bit_ff   <= bit_in;
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_payload_ff.clock_pin       <= clock_in;
         rsp_payload_ff.data_pin        <= data_in;
         rsp_payload_ff.sending         <= busy_in;
         rsp_payload_ff.update_finished <= finished;
         rsp_payload_ff.load_accepted   <= accepted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_low_ff    <= 64'd0;
         seg_high_ff   <= 16'd0;
         point_mask_ff <= POINT_MASK_RESET;
      end else if (csr.valid) begin
         unique case (csr_index_type'(csr.payload.reg_index))
            CSR_SEG_LOW:    seg_low_ff    <= csr.payload.write_data;
            CSR_SEG_HIGH:   seg_high_ff   <= csr.payload.write_data[15:0];
            CSR_POINT_MASK: point_mask_ff <= csr.payload.write_data[7:0];
            default: begin
            end
         endcase
      end
   end

endmodule

@@ rtl/core/four_digit_display_link_sender_core.sv @@
// Sends a four-digit value to a two-wire segment display, one pin change per item.
// The req channel carries items: a tick advances the link by one step, a load gives
// a new value to show (saturated to 9999) and is refused while an update is running.
// Every item produces exactly one item on the rsp channel with the pin levels, the
// sending flag, the end-of-update flag and whether a load was taken.
// The csr channel writes the segment tables and the decimal-point mask; it is always
// ready and should only be written while no update is running.
// An accepted item is registered in the queue and then in the output register before
// it shows up on rsp. With rsp ready held high the block takes and returns one
// item every cycle; the sequencer in the back stage advances once per tick and never
// holds back that rate.
// An accepted load starts a registered conversion into thousands, hundreds, tens
// and units, finished long before the first segment byte is needed.
// When rsp stalls, the result is held in the output register and the queue between
// front and back absorbs up to QUEUE_DEPTH further items before req_port.ready falls.
// After reset both pins are high, no update is running, the queue is empty, the
// segment tables are zero and the point mask is 0x80.
module four_digit_display_link_sender_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input logic          clock,
   input logic          reset,
   fddls_chan_if.sink   req_port,
   fddls_chan_if.source rsp_port,
   fddls_chan_if.sink   csr_port
);
   import fddls_pkg::*;

   logic        push_valid;
   logic        push_ready;
   item_type    push_item;
   logic        pop_valid;
   logic        pop_ready;
   item_type    pop_item;
   bcd_req_type bcd_req;
   digits_type  digits;

   fddls_front u_front (
      .req        (req_port),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   fddls_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   fddls_bcd u_bcd (
      .clock   (clock),
      .bcd_req (bcd_req),
      .digits  (digits)
   );

   fddls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .csr       (csr_port),
      .bcd_req   (bcd_req),
      .digits    (digits),
      .rsp       (rsp_port)
   );

endmodule

@@ rtl/core/fddls_checker.sv @@
module fddls_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input fddls_pkg::rsp_payload_type rsp_payload
);
   import fddls_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result item changed or was dropped.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.load_accepted |->
         rsp_payload.sending && !rsp_payload.update_finished)
      else $error("Accepted load did not start an update.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.update_finished |-> !rsp_payload.sending)
      else $error("Update finished while still sending.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.sending |-> rsp_payload.clock_pin && rsp_payload.data_pin)
      else $error("Link lines not released while idle.");

endmodule

bind four_digit_display_link_sender_core fddls_checker u_fddls_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .rsp_payload (rsp_port.payload)
);

@@ verif/four_digit_display_link_sender_core_check.sv @@
`timescale 1ns / 100ps

module four_digit_display_link_sender_core_check
   import fddls_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  csr_payload_type csr_payload,
   output int unsigned     pending_count,
   output int unsigned     fail_count
);

   logic [63:0] seg_low;
   logic [15:0] seg_high;
   logic [7:0]  point_bits;

   logic        line_clock;
   logic        line_data;
   logic [3:0]  digits [4];
   logic [2:0]  frame;
   logic        second_byte;
   logic [3:0]  slot;
   logic [1:0]  step;
   logic        busy;

   rsp_payload_type pin_levels_due [$];

   function automatic logic [7:0] segment_byte(input logic [3:0] digit);
      if (digit < 4'd8) begin
         return seg_low[8 * digit +: 8];
      end else if (digit < 4'd10) begin
         return seg_high[8 * (digit - 4'd8) +: 8];
      end
      return 8'h00;
   endfunction

   function automatic logic [7:0] frame_byte();
      logic [1:0] place;
      logic [7:0] pattern;
      if (frame == 3'd0) begin
         return CMD_DATA_MODE;
      end else if (frame >= LAST_FRAME) begin
         return CMD_DISPLAY_ON;
      end else if (!second_byte) begin
         return CMD_ADDRESS_BASE + 8'(frame - 3'd1);
      end
      place = 2'(frame - 3'd1);
      pattern = segment_byte(digits[place]);
      if (place == 2'd1) begin
         pattern = pattern | point_bits;
      end
      return pattern;
   endfunction

   // Moves the link on by one pin change and reports whether the update ended.
   function automatic logic advance_link();
      logic [7:0] outgoing;
      logic       done;
      outgoing = frame_byte();
      done = 1'b0;
      if (slot < SEG_ACK) begin
         case (step)
            2'd0: line_clock = 1'b0;
            2'd1: line_data = outgoing[slot[2:0]];
            default: line_clock = 1'b1;
         endcase
         if (step >= 2'd2) begin
            step = 2'd0;
            slot = slot + 4'd1;
         end else begin
            step = step + 2'd1;
         end
      end else if (slot == SEG_ACK) begin
         case (step)
            2'd0: line_clock = 1'b0;
            2'd1: line_data = 1'b1;
            default: line_clock = 1'b1;
         endcase
         if (step >= 2'd2) begin
            step = 2'd0;
            if (!second_byte && frame != 3'd0 && frame < LAST_FRAME) begin
               second_byte = 1'b1;
               slot = 4'd0;
            end else begin
               slot = SEG_STOP;
            end
         end else begin
            step = step + 2'd1;
         end
      end else if (slot == SEG_STOP) begin
         case (step)
            2'd0: line_clock = 1'b0;
            2'd1: line_data = 1'b0;
            2'd2: line_clock = 1'b1;
            default: line_data = 1'b1;
         endcase
         if (step >= 2'd3) begin
            step = 2'd0;
            second_byte = 1'b0;
            if (frame >= LAST_FRAME) begin
               frame = 3'd0;
               slot = 4'd0;
               busy = 1'b0;
               done = 1'b1;
            end else begin
               frame = frame + 3'd1;
               slot = SEG_START;
            end
         end else begin
            step = step + 2'd1;
         end
      end else begin
         case (step)
            2'd0: begin
               line_clock = 1'b1;
               line_data = 1'b1;
            end
            2'd1: line_data = 1'b0;
            default: line_clock = 1'b0;
         endcase
         if (step >= 2'd2) begin
            step = 2'd0;
            slot = 4'd0;
         end else begin
            step = step + 2'd1;
         end
      end
      return done;
   endfunction

   function automatic rsp_payload_type predict_pin_levels(input req_payload_type item);
      rsp_payload_type levels;
      int unsigned     shown;
      levels = '0;
      if (item.opcode) begin
         if (!busy) begin
            shown = (item.shown_value > VALUE_MAX) ? VALUE_MAX : item.shown_value;
            digits[0] = 4'(shown / 1000);
            digits[1] = 4'((shown % 1000) / 100);
            digits[2] = 4'((shown % 100) / 10);
            digits[3] = 4'(shown % 10);
            frame = 3'd0;
            second_byte = 1'b0;
            slot = SEG_START;
            step = 2'd0;
            busy = 1'b1;
            levels.load_accepted = 1'b1;
         end
      end else if (busy) begin
         levels.update_finished = advance_link();
      end
      levels.clock_pin = line_clock;
      levels.data_pin = line_data;
      levels.sending = busy;
      return levels;
   endfunction

   function automatic void compare_pin(input string field, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", field, want, got);
         fail_count = fail_count + 1;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type due;
      if (reset) begin
         seg_low = '0;
         seg_high = '0;
         point_bits = POINT_MASK_RESET;
         line_clock = 1'b1;
         line_data = 1'b1;
         digits = '{default: 4'd0};
         frame = 3'd0;
         second_byte = 1'b0;
         slot = 4'd0;
         step = 2'd0;
         busy = 1'b0;
         pin_levels_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pin_levels_due.size() == 0) begin
               $error("rsp item arrived with nothing expected");
               fail_count = fail_count + 1;
            end else begin
               due = pin_levels_due.pop_front();
               compare_pin("clock_pin", due.clock_pin, rsp_payload.clock_pin);
               compare_pin("data_pin", due.data_pin, rsp_payload.data_pin);
               compare_pin("sending", due.sending, rsp_payload.sending);
               compare_pin("update_finished", due.update_finished,
                           rsp_payload.update_finished);
               compare_pin("load_accepted", due.load_accepted, rsp_payload.load_accepted);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_payload.reg_index))
               CSR_SEG_LOW: seg_low = csr_payload.write_data;
               CSR_SEG_HIGH: seg_high = csr_payload.write_data[15:0];
               CSR_POINT_MASK: point_bits = csr_payload.write_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pin_levels_due.push_back(predict_pin_levels(req_payload));
         end
      end
      pending_count <= pin_levels_due.size();
   end

endmodule

@@ verif/four_digit_display_link_sender_core_tb.sv @@
`timescale 1ns / 100ps

module four_digit_display_link_sender_core_tb;
   import fddls_pkg::*;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // Six frames of start, bytes with ack slots and stop take exactly this many ticks.
   localparam int unsigned UPDATE_TICKS = 312;
   localparam int unsigned NOISE_PERCENT = 15;
   localparam int unsigned IDLE_PERCENT = 23;
   localparam int unsigned HOLD_OFF_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        calm;
   logic        hold_go;
   bit          hold_used;
   int unsigned pending_count;
   int unsigned fail_count;

   fddls_chan_if #(.payload_type(req_payload_type)) req_if ();
   fddls_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   fddls_chan_if #(.payload_type(csr_payload_type)) csr_if ();

   four_digit_display_link_sender_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   four_digit_display_link_sender_core_check link_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_payload   (req_if.payload),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_payload   (rsp_if.payload),
      .csr_valid     (csr_if.valid),
      .csr_ready     (csr_if.ready),
      .csr_payload   (csr_if.payload),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("four_digit_display_link_sender_core_tb failed");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_used) begin
            hold_used = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic send_item(input logic op, input logic [13:0] value);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= req_payload_type'{opcode: op, shown_value: value};
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_settings(input logic [63:0] low_table, input logic [15:0] high_table,
                                 input logic [7:0] point);
      csr_if.valid <= 1'b1;
      csr_if.payload <= csr_payload_type'{reg_index: CSR_SEG_LOW, write_data: low_table};
      do @(posedge clock); while (!csr_if.ready);
      csr_if.payload <= csr_payload_type'{reg_index: CSR_SEG_HIGH,
                                          write_data: 64'(high_table)};
      do @(posedge clock); while (!csr_if.ready);
      csr_if.payload <= csr_payload_type'{reg_index: CSR_POINT_MASK, write_data: 64'(point)};
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // Loads a value and ticks the whole update through, with refused loads mixed in.
   task automatic run_update(input logic [13:0] value, input int unsigned noise);
      int unsigned ticks;
      ticks = 0;
      send_item(OP_LOAD, value);
      while (ticks < UPDATE_TICKS) begin
         if ($urandom_range(99) < noise) begin
            send_item(OP_LOAD, 14'($urandom));
         end else begin
            send_item(OP_TICK, 14'($urandom));
            ticks = ticks + 1;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      hold_go = 1'b0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_settings(64'h077D_6D66_4F5B_063F, 16'h6F7F, POINT_MASK_RESET);
      send_item(OP_TICK, 14'h0000);
      send_item(OP_TICK, 14'h3FFF);
      send_item(OP_LOAD, 14'h3FFF);
      send_item(OP_LOAD, 14'h0000);
      send_item(OP_LOAD, 14'd1234);
      run_update(14'd0, 0);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: write_settings('0, '0, '0);
            1: write_settings('1, '1, '1);
            default: write_settings({$urandom, $urandom}, 16'($urandom), 8'($urandom));
         endcase
         calm <= (phase == 2);
         hold_go <= (phase == 2);
         case (phase)
            0: run_update(VALUE_MAX, NOISE_PERCENT);
            1: run_update(14'd10000, NOISE_PERCENT);
            default: run_update(14'($urandom), NOISE_PERCENT);
         endcase
         repeat ($urandom_range(3)) send_item(OP_TICK, 14'($urandom));
         wait_drained();
         calm <= 1'b0;
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("four_digit_display_link_sender_core_tb passed");
      end else begin
         $display("four_digit_display_link_sender_core_tb failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/fddls_pkg.sv
rtl/core/fddls_chan_if.sv
rtl/core/fddls_front.sv
rtl/core/fddls_queue.sv
rtl/core/fddls_bcd.sv
rtl/core/fddls_back.sv
rtl/core/four_digit_display_link_sender_core.sv
rtl/core/fddls_checker.sv
verif/four_digit_display_link_sender_core_check.sv
verif/four_digit_display_link_sender_core_tb.sv
